// ===== rtl/kctt_pkg.sv =====
// Shared constants, request codes and record types for the countdown timer table.
`default_nettype none
package kctt_pkg;

    localparam int ENTRIES = 16;
    localparam int MAX_OUT = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int NM_W    = $clog2(MAX_OUT + 1);

    localparam int REQ_W   = 4;
    localparam int KEY_W   = 32;
    localparam int DUR_W   = 32;
    localparam int PROG_W  = 17;
    localparam int ACT_W   = 5;
    localparam int STEP_W  = $clog2(PROG_W + 1);

    localparam logic [DUR_W-1:0] THRESH_RST = 32'd5000;

    localparam logic [REQ_W-1:0] REQ_ADD    = 4'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 4'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 4'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_EXP    = 4'd4;
    localparam logic [REQ_W-1:0] REQ_BUFF   = 4'd5;
    localparam logic [REQ_W-1:0] REQ_DEBUFF = 4'd6;
    localparam logic [REQ_W-1:0] REQ_ALL    = 4'd7;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 4'd8;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [DUR_W-1:0] total;
        logic [DUR_W-1:0] remaining;
        logic             debuff;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] spell_id;
        logic [DUR_W-1:0] total_duration;
        logic [DUR_W-1:0] remaining_duration;
        logic             is_debuff;
        logic [DUR_W-1:0] tick_amount;
    } t_req;

    typedef struct packed {
        logic              status;
        logic              found;
        logic              entry_valid;
        logic [KEY_W-1:0]  out_id;
        logic [DUR_W-1:0]  out_total;
        logic [DUR_W-1:0]  out_remaining;
        logic              out_debuff;
        logic [PROG_W-1:0] progress;
        logic              expired;
        logic [ACT_W-1:0]  active_count;
        logic              last;
    } t_rsp;

    function automatic t_rsp with_entry(t_rsp r, t_entry e);
        t_rsp o;
        o               = r;
        o.entry_valid   = 1'b1;
        o.out_id        = e.key;
        o.out_total     = e.total;
        o.out_remaining = e.remaining;
        o.out_debuff    = e.debuff;
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/kctt_req_if.sv =====
// Request channel carrying one timer request per beat.
`default_nettype none
interface kctt_req_if import kctt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] spell_id;
    logic [DUR_W-1:0] total_duration;
    logic [DUR_W-1:0] remaining_duration;
    logic             is_debuff;
    logic [DUR_W-1:0] tick_amount;

    modport source (output valid, req_type, spell_id, total_duration, remaining_duration,
                    is_debuff, tick_amount, input ready);
    modport sink (input valid, req_type, spell_id, total_duration, remaining_duration,
                  is_debuff, tick_amount, output ready);
endinterface
`default_nettype wire

// ===== rtl/kctt_rsp_if.sv =====
// Response channel carrying one result per beat.
`default_nettype none
interface kctt_rsp_if import kctt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic              found;
    logic              entry_valid;
    logic [KEY_W-1:0]  out_id;
    logic [DUR_W-1:0]  out_total;
    logic [DUR_W-1:0]  out_remaining;
    logic              out_debuff;
    logic [PROG_W-1:0] progress;
    logic              expired;
    logic [ACT_W-1:0]  active_count;
    logic              last;

    modport source (output valid, status, found, entry_valid, out_id, out_total,
                    out_remaining, out_debuff, progress, expired, active_count, last,
                    input ready);
    modport sink (input valid, status, found, entry_valid, out_id, out_total,
                  out_remaining, out_debuff, progress, expired, active_count, last,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/kctt_cfg_if.sv =====
// Configuration write channel for the expiring threshold register.
`default_nettype none
interface kctt_cfg_if import kctt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] expiring_threshold;

    modport source (output valid, expiring_threshold, input ready);
    modport sink (input valid, expiring_threshold, output ready);
endinterface
`default_nettype wire

// ===== rtl/kctt_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module kctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/kctt_div.sv =====
// Restoring divider that forms the Q1.16 progress ratio one quotient bit per cycle.
`default_nettype none
module kctt_div import kctt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DUR_W-1:0]  i_num,
    input  wire logic [DUR_W-1:0]  i_den,
    output logic                   o_done,
    output logic [PROG_W-1:0]      o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DUR_W:0]    r_rem;
    logic [DUR_W-1:0]  r_den;
    logic [PROG_W-1:0] r_quot;
    logic              ge;
    logic [DUR_W:0]    diff;
    logic [DUR_W:0]    n_rem;

    assign ge    = r_rem >= {1'b0, r_den};
    assign diff  = r_rem - {1'b0, r_den};
    assign n_rem = ge ? {diff[DUR_W-1:0], 1'b0} : {r_rem[DUR_W-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
            r_step <= STEP_W'(PROG_W);
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[PROG_W-2:0], ge};
            r_step <= r_step - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ===== rtl/keyed_countdown_timer_table.sv =====
// Keyed countdown timer table: sequencer, entry memory, progress divider and result register.
// Add, remove, tick, query and listings walk the stored entries over the single memory read port,
// reading an entry in S_RD and checking it in S_CHK. Add and query stop at a key hit; listings
// stop at MAX_OUT results and wait in S_CHK while the output register is full. Clear and unused
// codes go straight to S_FIN; a query hit with a valid ratio waits in S_DIV for the divider.
// The next request is accepted when the sequencer is back in idle after the final result.
// Reset empties the table and loads the expiring threshold with 5000; entry storage is not cleared.
`default_nettype none
module keyed_countdown_timer_table import kctt_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    kctt_cfg_if.sink  i_cfg,
    kctt_req_if.sink  i_req,
    kctt_rsp_if.source o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DUR_W-1:0]  r_thresh;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out;
    t_req              r_req, n_req;
    logic [CNT_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_wr, n_wr;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [IDX_W-1:0]  r_hit, n_hit;
    logic              r_found, n_found;
    logic              r_pend, n_pend;
    logic [NM_W-1:0]   r_nm, n_nm;
    t_entry            r_ent, n_ent;
    logic [PROG_W-1:0] r_prog, n_prog;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_entry            ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry            rd_ent;
    t_entry            req_ent;

    logic              div_start;
    logic              div_done;
    logic [PROG_W-1:0] div_quot;

    logic              emit;
    t_rsp              e_rsp;
    logic              out_free;
    logic              key_hit;
    logic              list_hit;
    logic              is_list;
    logic [DUR_W-1:0]  tick_rem;
    logic [CNT_W-1:0]  cnt_inc;

    kctt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    kctt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (rd_ent.total - rd_ent.remaining),
        .i_den   (rd_ent.total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign rd_ent   = t_entry'(ram_rdata);
    assign req_ent  = '{key: r_req.spell_id, total: r_req.total_duration,
                        remaining: r_req.remaining_duration, debuff: r_req.is_debuff};
    assign out_free = !r_out_valid || o_rsp.ready;
    assign key_hit  = rd_ent.key == r_req.spell_id;
    assign is_list  = r_req.req_type inside {[REQ_EXP:REQ_ALL]};
    assign tick_rem = (rd_ent.remaining > r_req.tick_amount) ?
                      (rd_ent.remaining - r_req.tick_amount) : '0;
    assign cnt_inc  = r_count + 1'b1;

    always_comb begin
        case (r_req.req_type)
            REQ_EXP:    list_hit = (rd_ent.remaining != '0) && (rd_ent.remaining < r_thresh);
            REQ_BUFF:   list_hit = !rd_ent.debuff;
            REQ_DEBUFF: list_hit = rd_ent.debuff;
            default:    list_hit = 1'b1;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_req     = r_req;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_cur     = r_cur;
        n_hit     = r_hit;
        n_found   = r_found;
        n_pend    = r_pend;
        n_nm      = r_nm;
        n_ent     = r_ent;
        n_prog    = r_prog;
        ram_we    = 1'b0;
        ram_waddr = r_wr[IDX_W-1:0];
        ram_wdata = rd_ent;
        ram_re    = 1'b0;
        ram_raddr = r_rd[IDX_W-1:0];
        div_start = 1'b0;
        emit      = 1'b0;
        e_rsp     = '0;
        e_rsp.active_count = ACT_W'(r_count);

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req = '{req_type: i_req.req_type, spell_id: i_req.spell_id,
                              total_duration: i_req.total_duration,
                              remaining_duration: i_req.remaining_duration,
                              is_debuff: i_req.is_debuff, tick_amount: i_req.tick_amount};
                    n_rd    = '0;
                    n_wr    = '0;
                    n_found = 1'b0;
                    n_pend  = 1'b0;
                    n_nm    = '0;
                    n_prog  = '0;
                    if (i_req.req_type inside {[REQ_ADD:REQ_ALL]}) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RD: begin
                if (r_rd < r_count && !(is_list && r_nm == NM_W'(MAX_OUT))) begin
                    ram_re  = 1'b1;
                    n_cur   = r_rd[IDX_W-1:0];
                    n_rd    = r_rd + 1'b1;
                    n_state = S_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CHK: begin
                case (r_req.req_type)
                    REQ_ADD: begin
                        if (key_hit) begin
                            n_found = 1'b1;
                            n_hit   = r_cur;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    REQ_REMOVE: begin
                        if (key_hit) begin
                            n_found = 1'b1;
                        end else begin
                            ram_we = 1'b1;
                            n_wr   = r_wr + 1'b1;
                        end
                        n_state = S_RD;
                    end
                    REQ_TICK: begin
                        if (tick_rem != '0) begin
                            ram_we              = 1'b1;
                            ram_wdata.remaining = tick_rem;
                            n_wr                = r_wr + 1'b1;
                        end
                        n_state = S_RD;
                    end
                    REQ_QUERY: begin
                        if (key_hit) begin
                            n_found = 1'b1;
                            n_ent   = rd_ent;
                            if (rd_ent.total != '0 && rd_ent.remaining <= rd_ent.total) begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end else begin
                                n_state = S_FIN;
                            end
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        if (!list_hit) begin
                            n_state = S_RD;
                        end else if (!r_pend || out_free) begin
                            if (r_pend) begin
                                emit  = 1'b1;
                                e_rsp = with_entry(e_rsp, r_ent);
                            end
                            n_ent   = rd_ent;
                            n_pend  = 1'b1;
                            n_nm    = r_nm + 1'b1;
                            n_state = S_RD;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_prog  = div_quot;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_rsp.last = 1'b1;
                    n_state    = S_IDLE;
                    case (r_req.req_type)
                        REQ_ADD: begin
                            if (r_found) begin
                                ram_we      = 1'b1;
                                ram_waddr   = r_hit;
                                ram_wdata   = req_ent;
                                e_rsp       = with_entry(e_rsp, req_ent);
                                e_rsp.found = 1'b1;
                            end else if (r_count >= CNT_W'(ENTRIES)) begin
                                e_rsp.status = 1'b1;
                            end else begin
                                ram_we             = 1'b1;
                                ram_waddr          = r_count[IDX_W-1:0];
                                ram_wdata          = req_ent;
                                n_count            = cnt_inc;
                                e_rsp              = with_entry(e_rsp, req_ent);
                                e_rsp.active_count = ACT_W'(cnt_inc);
                            end
                        end
                        REQ_REMOVE: begin
                            n_count            = r_wr;
                            e_rsp.found        = r_found;
                            e_rsp.active_count = ACT_W'(r_wr);
                        end
                        REQ_TICK: begin
                            n_count            = r_wr;
                            e_rsp.active_count = ACT_W'(r_wr);
                        end
                        REQ_QUERY: begin
                            if (r_found) begin
                                e_rsp          = with_entry(e_rsp, r_ent);
                                e_rsp.found    = 1'b1;
                                e_rsp.progress = r_prog;
                                e_rsp.expired  = (r_ent.remaining == '0);
                            end else begin
                                e_rsp.expired = 1'b1;
                            end
                        end
                        REQ_EXP, REQ_BUFF, REQ_DEBUFF, REQ_ALL: begin
                            if (r_pend) begin
                                e_rsp = with_entry(e_rsp, r_ent);
                            end
                        end
                        REQ_CLEAR: begin
                            n_count            = '0;
                            e_rsp.active_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = emit ? 1'b1 : (o_rsp.ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_thresh    <= THRESH_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_thresh <= i_cfg.expiring_threshold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_rd    <= n_rd;
        r_wr    <= n_wr;
        r_cur   <= n_cur;
        r_hit   <= n_hit;
        r_found <= n_found;
        r_pend  <= n_pend;
        r_nm    <= n_nm;
        r_ent   <= n_ent;
        r_prog  <= n_prog;
        if (emit) begin
            r_out <= e_rsp;
        end
    end

    assign i_cfg.ready         = 1'b1;
    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.found         = r_out.found;
    assign o_rsp.entry_valid   = r_out.entry_valid;
    assign o_rsp.out_id        = r_out.out_id;
    assign o_rsp.out_total     = r_out.out_total;
    assign o_rsp.out_remaining = r_out.out_remaining;
    assign o_rsp.out_debuff    = r_out.out_debuff;
    assign o_rsp.progress      = r_out.progress;
    assign o_rsp.expired       = r_out.expired;
    assign o_rsp.active_count  = r_out.active_count;
    assign o_rsp.last          = r_out.last;

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("Result produced while the output register is still occupied.");

    a_compact_behind_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_wr < r_rd))
        else $error("Compaction write index caught up with the read index.");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("Divider finished outside the division wait.");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && emit) |=> (r_count <= CNT_W'(ENTRIES)))
        else $error("Entry count exceeds the table depth.");

    a_tick_no_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && emit && (r_req.req_type == REQ_TICK ||
         r_req.req_type == REQ_REMOVE)) |=> (r_count <= $past(r_count)))
        else $error("Tick or remove increased the entry count.");

endmodule
`default_nettype wire
